@@ rtl/rlfh_pkg.sv @@
// shared constants, status and command codes, and result type for the recursive lock
package rlfh_pkg;

    localparam int WAITER_DEPTH = 16;
    localparam int ID_BITS      = 8;
    localparam int COUNT_BITS   = 16;

    localparam int PTR_BITS  = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
    localparam int FILL_BITS = $clog2(WAITER_DEPTH + 1);

    localparam int CMD_W    = 2;
    localparam int REQ_W    = 8;
    localparam int STATUS_W = 3;

    localparam logic [CMD_W-1:0] CMD_TRYLOCK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOCK    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNLOCK  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_OWNER = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SAT       = 3'd4;

    typedef logic [ID_BITS-1:0]    id_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [PTR_BITS-1:0]   ptr_t;
    typedef logic [FILL_BITS-1:0]  fill_t;

    typedef struct packed {
        logic                granted;
        logic                queued;
        logic                handoff_valid;
        id_t                 handoff_to;
        logic                now_free;
        logic [STATUS_W-1:0] status;
    } rlfh_result_t;

endpackage

@@ rtl/rlfh_core.sv @@
// lock state, waiter queue and per-request decision logic
module rlfh_core
    import rlfh_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic [CMD_W-1:0]   cmd,
    input  id_t                req,
    output rlfh_result_t       result
);

    localparam ptr_t   LAST_POS  = PTR_BITS'(WAITER_DEPTH - 1);
    localparam fill_t  FULL_FILL = FILL_BITS'(WAITER_DEPTH);
    localparam count_t COUNT_MAX = '1;

    logic   owner_valid_reg, owner_valid_next;
    id_t    owner_id_reg, owner_id_next;
    count_t hold_count_reg, hold_count_next;
    ptr_t   head_reg, head_next;
    ptr_t   tail_reg, tail_next;
    fill_t  fill_reg, fill_next;
    id_t    waiter_reg [WAITER_DEPTH];
    logic   push;
    id_t    head_id;
    logic   mine;
    logic   other;

    assign mine    = owner_valid_reg && (owner_id_reg == req);
    assign other   = owner_valid_reg && (owner_id_reg != req);
    assign head_id = waiter_reg[head_reg];

    always_comb begin
        owner_valid_next = owner_valid_reg;
        owner_id_next    = owner_id_reg;
        hold_count_next  = hold_count_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        fill_next        = fill_reg;
        push             = 1'b0;
        result           = '0;
        result.status    = ST_OK;

        case (cmd)
            CMD_TRYLOCK, CMD_LOCK: begin
                if (other) begin
                    if (cmd == CMD_TRYLOCK) begin
                        result.status = ST_BUSY;
                    end else if (fill_reg == FULL_FILL) begin
                        result.status = ST_FULL;
                    end else begin
                        push          = 1'b1;
                        tail_next     = (tail_reg == LAST_POS) ? '0 : tail_reg + 1'b1;
                        fill_next     = fill_reg + 1'b1;
                        result.queued = 1'b1;
                    end
                end else if (mine && hold_count_reg == COUNT_MAX) begin
                    result.status = ST_SAT;
                end else begin
                    // a free lock starts counting from one
                    owner_valid_next = 1'b1;
                    owner_id_next    = req;
                    hold_count_next  = owner_valid_reg ? hold_count_reg + 1'b1
                                                       : COUNT_BITS'(1);
                    result.granted   = 1'b1;
                end
            end
            CMD_UNLOCK: begin
                if (!mine) begin
                    result.status = ST_NOT_OWNER;
                end else if (hold_count_reg > COUNT_BITS'(1)) begin
                    hold_count_next = hold_count_reg - 1'b1;
                end else if (fill_reg != '0) begin
                    // last release hands the lock to the oldest waiter
                    owner_id_next        = head_id;
                    head_next            = (head_reg == LAST_POS) ? '0 : head_reg + 1'b1;
                    fill_next            = fill_reg - 1'b1;
                    hold_count_next      = COUNT_BITS'(1);
                    result.handoff_valid = 1'b1;
                    result.handoff_to    = head_id;
                end else begin
                    owner_valid_next = 1'b0;
                    owner_id_next    = '0;
                    hold_count_next  = '0;
                end
            end
            default: begin
            end
        endcase

        result.now_free = !owner_valid_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owner_valid_reg <= 1'b0;
            owner_id_reg    <= '0;
            hold_count_reg  <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            fill_reg        <= '0;
        end else if (step) begin
            owner_valid_reg <= owner_valid_next;
            owner_id_reg    <= owner_id_next;
            hold_count_reg  <= hold_count_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            fill_reg        <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && push) begin
            waiter_reg[tail_reg] <= req;
        end
    end

endmodule

@@ rtl/recursive_lock_fifo_handoff.sv @@
// top level: request input register, lock core and result register
// a request passes the input register and the lock core into the result register
// throughput: one request per cycle unless stalled; the owner, count and queue
// update in one pass; both registers stall together only while m_ready is low
// reset: synchronous active-low aresetn frees the lock and empties the queue
// waiter entries are not cleared; only written entries are ever read
module recursive_lock_fifo_handoff
    import rlfh_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [REQ_W-1:0]    s_requester,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_granted,
    output logic                m_queued,
    output logic                m_handoff_valid,
    output logic [REQ_W-1:0]    m_handoff_to,
    output logic                m_now_free,
    output logic [STATUS_W-1:0] m_status
);

    logic             in_valid_reg;
    logic [CMD_W-1:0] cmd_reg;
    id_t              req_reg;
    logic             m_valid_reg;
    rlfh_result_t     res_reg;
    rlfh_result_t     core_res;
    logic             advance;

    // item moves to the result register when that register is free or being drained
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_cmd;
            req_reg <= ID_BITS'(s_requester);
        end
    end

    rlfh_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .cmd     (cmd_reg),
        .req     (req_reg),
        .result  (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= core_res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_granted       = res_reg.granted;
    assign m_queued        = res_reg.queued;
    assign m_handoff_valid = res_reg.handoff_valid;
    assign m_handoff_to    = REQ_W'(res_reg.handoff_to);
    assign m_now_free      = res_reg.now_free;
    assign m_status        = res_reg.status;

    a_handoff_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_handoff_valid |-> !m_now_free && !m_granted && !m_queued)
        else $error("handoff result shows a free lock or a grant");

    a_grant_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_granted |-> !m_now_free && m_status == ST_OK)
        else $error("grant result inconsistent");

    a_error_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> !m_granted && !m_queued && !m_handoff_valid)
        else $error("error status together with a state change");

    a_stall_only_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && m_valid_reg && !m_ready)
        else $error("input stalled while the pipeline could move");

endmodule
